/* rtl/elevator_request_scheduler_defines.svh */
// Assertion macros used by the scheduler top-level RTL.
`ifndef ELEVATOR_REQUEST_SCHEDULER_DEFINES_SVH
`define ELEVATOR_REQUEST_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ERS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ERS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ers_pkg.sv */
// Types and constants of the elevator request scheduler.
package ers_pkg;

	localparam int unsigned FLOOR_W = 7;
	localparam logic [FLOOR_W-1:0] FLOOR_CNT_RESET = 7'd10;
	localparam logic [FLOOR_W-1:0] CAR_RESET = 7'd1;

	// Request codes
	localparam logic [1:0] REQ_ADD_UP = 2'd0;
	localparam logic [1:0] REQ_ADD_DOWN = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	typedef enum logic [1:0] {
		DIR_IDLE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} ers_dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DECIDE,
		ST_READ,
		ST_WRITE,
		ST_DONE
	} ers_state_t;

	// Hall-call flags of one floor
	typedef struct packed {
		logic up;
		logic dn;
	} ers_flags_t;

	// One floor's flags on their way from the flag memory to the target scan
	typedef struct packed {
		logic               vld;
		logic [FLOOR_W-1:0] floor;
		ers_flags_t         flags;
	} ers_scan_beat_t;

endpackage

/* rtl/ers_req_if.sv */
// Request channel: call additions and time steps.
interface ers_req_if import ers_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [FLOOR_W-1:0] call_floor;

	modport source (output valid, output req_type, output call_floor, input ready);
	modport sink (input valid, input req_type, input call_floor, output ready);
endinterface

/* rtl/ers_rsp_if.sv */
// Result channel: car status after each request.
interface ers_rsp_if import ers_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FLOOR_W-1:0] car_floor;
	logic [1:0]         travel_dir;
	logic               car_moved;
	logic               served_up_call;
	logic               served_down_call;
	logic               door_cycle;
	logic               calls_pending;
	logic               call_rejected;

	modport source (output valid, output car_floor, output travel_dir, output car_moved,
		output served_up_call, output served_down_call, output door_cycle,
		output calls_pending, output call_rejected, input ready);
	modport sink (input valid, input car_floor, input travel_dir, input car_moved,
		input served_up_call, input served_down_call, input door_cycle,
		input calls_pending, input call_rejected, output ready);
endinterface

/* rtl/ers_flag_mem.sv */
// Per-floor hall-call flag memory with registered read and valid bits.
module ers_flag_mem import ers_pkg::*; #(
	parameter int unsigned DEPTH = 65,
	parameter int unsigned AW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output ers_flags_t    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  ers_flags_t    wr_data
);

	ers_flags_t       mem [DEPTH];
	ers_flags_t       rdata_q;
	logic             rvalid_q;
	logic [DEPTH-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Entries never written read as cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

/* rtl/ers_target_scan.sv */
// Floor-by-floor accumulation of call candidates and target floor choice.
module ers_target_scan import ers_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ers_scan_beat_t     beat,
	input  logic [FLOOR_W-1:0] car,
	input  ers_dir_t           dir,
	output logic [FLOOR_W-1:0] target,
	output logic [FLOOR_W-1:0] pend_cnt
);

	logic               up_above_ok_q, dn_high_ok_q, dn_below_ok_q, up_low_ok_q;
	logic               up_near_ok_q, dn_near_ok_q;
	logic [FLOOR_W-1:0] up_above_q, dn_high_q, dn_below_q, up_low_q;
	logic [FLOOR_W-1:0] up_near_q, dn_near_q, up_dist_q, dn_dist_q;
	logic [FLOOR_W-1:0] cnt_q;
	logic [FLOOR_W-1:0] floor_gap;
	logic [FLOOR_W-1:0] nearest;

	assign floor_gap = (beat.floor > car) ? beat.floor - car : car - beat.floor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_above_ok_q <= 1'b0;
			dn_high_ok_q  <= 1'b0;
			dn_below_ok_q <= 1'b0;
			up_low_ok_q   <= 1'b0;
			up_near_ok_q  <= 1'b0;
			dn_near_ok_q  <= 1'b0;
			cnt_q         <= '0;
		end else if (start) begin
			up_above_ok_q <= 1'b0;
			dn_high_ok_q  <= 1'b0;
			dn_below_ok_q <= 1'b0;
			up_low_ok_q   <= 1'b0;
			up_near_ok_q  <= 1'b0;
			dn_near_ok_q  <= 1'b0;
			cnt_q         <= '0;
		end else if (beat.vld) begin
			if (beat.flags.up || beat.flags.dn) begin
				cnt_q <= cnt_q + 7'd1;
			end
			// Floors arrive in ascending order: first hit is lowest, last is highest
			if (beat.flags.up && beat.floor > car && !up_above_ok_q) begin
				up_above_ok_q <= 1'b1;
			end
			if (beat.flags.dn) begin
				dn_high_ok_q <= 1'b1;
			end
			if (beat.flags.dn && beat.floor < car) begin
				dn_below_ok_q <= 1'b1;
			end
			if (beat.flags.up) begin
				up_low_ok_q <= 1'b1;
			end
			if (beat.flags.up && (!up_near_ok_q || floor_gap < up_dist_q)) begin
				up_near_ok_q <= 1'b1;
			end
			if (beat.flags.dn && (!dn_near_ok_q || floor_gap < dn_dist_q)) begin
				dn_near_ok_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat.vld && !start) begin
			if (beat.flags.up && beat.floor > car && !up_above_ok_q) begin
				up_above_q <= beat.floor;
			end
			if (beat.flags.dn) begin
				dn_high_q <= beat.floor;
			end
			if (beat.flags.dn && beat.floor < car) begin
				dn_below_q <= beat.floor;
			end
			if (beat.flags.up && !up_low_ok_q) begin
				up_low_q <= beat.floor;
			end
			if (beat.flags.up && (!up_near_ok_q || floor_gap < up_dist_q)) begin
				up_near_q <= beat.floor;
				up_dist_q <= floor_gap;
			end
			if (beat.flags.dn && (!dn_near_ok_q || floor_gap < dn_dist_q)) begin
				dn_near_q <= beat.floor;
				dn_dist_q <= floor_gap;
			end
		end
	end

	// Nearest call; an up call wins on equal distance
	always_comb begin
		if (up_near_ok_q && dn_near_ok_q) begin
			nearest = (up_dist_q <= dn_dist_q) ? up_near_q : dn_near_q;
		end else if (up_near_ok_q) begin
			nearest = up_near_q;
		end else if (dn_near_ok_q) begin
			nearest = dn_near_q;
		end else begin
			nearest = car;
		end
	end

	always_comb begin
		case (dir)
			DIR_UP: begin
				if (up_above_ok_q) begin
					target = up_above_q;
				end else if (dn_high_ok_q) begin
					target = dn_high_q;
				end else begin
					target = nearest;
				end
			end
			DIR_DOWN: begin
				if (dn_below_ok_q) begin
					target = dn_below_q;
				end else if (up_low_ok_q) begin
					target = up_low_q;
				end else begin
					target = nearest;
				end
			end
			default: begin
				target = nearest;
			end
		endcase
	end

	assign pend_cnt = cnt_q;

endmodule

/* rtl/elevator_request_scheduler.sv */
// Elevator request scheduler: the car holds one up and one down hall-call flag per floor in a
// flag memory, and each request (add up call, add down call, or one time step) returns one
// status beat. Every request scans floors 1..n of the flag memory, one floor per cycle through
// its single read port, where n is the floor count in use (the smaller of the configured
// count and MAX_FLOOR_COUNT). An added call or a tick with pending calls reads, modifies and
// writes back one flag entry before its result beat is loaded; a rejected call, a tick with
// nothing pending or an unused code skips that write-back. A result beat is loaded only once
// the previous one has been taken. Flag memory entries carry valid bits cleared by reset, so
// the block accepts requests right after reset. Write the floor count only while no request
// is in flight.
`include "elevator_request_scheduler_defines.svh"

module elevator_request_scheduler import ers_pkg::*; #(
	parameter int unsigned MAX_FLOOR_COUNT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [FLOOR_W-1:0] cfg_wdata,
	ers_req_if.sink            req,
	ers_rsp_if.source          rsp
);

	localparam int unsigned DEPTH = MAX_FLOOR_COUNT + 1;
	localparam int unsigned AW = $clog2(DEPTH);

	ers_state_t         state_q, state_nxt;
	logic [FLOOR_W-1:0] floor_cnt_q;
	logic [FLOOR_W-1:0] n_use;
	logic [FLOOR_W-1:0] n_q;
	logic [1:0]         req_type_q;
	logic [FLOOR_W-1:0] cf_q;
	logic [FLOOR_W-1:0] scan_idx_q;
	logic [FLOOR_W-1:0] car_q;
	ers_dir_t           dir_q;
	logic [FLOOR_W-1:0] wr_floor_q;
	logic               moved_q, srv_up_q, srv_dn_q, pending_q, rejected_q;
	logic               scan_vld_s1;
	logic [FLOOR_W-1:0] floor_s1;

	logic               accept;
	logic               load_rsp;
	logic               mem_rd_en, mem_wr_en;
	logic [AW-1:0]      mem_rd_addr;
	ers_flags_t         mem_rd_data, mem_wr_data;
	ers_scan_beat_t     beat;
	logic [FLOOR_W-1:0] target, pend_cnt, new_car;
	logic               is_add, add_bad, is_tick, do_rmw, clr_in_use;
	logic [FLOOR_W-1:0] pend_left;

	logic               rsp_valid_q;
	logic [FLOOR_W-1:0] rsp_car_q;
	ers_dir_t           rsp_dir_q;
	logic               rsp_moved_q, rsp_up_q, rsp_dn_q, rsp_pend_q, rsp_rej_q;

	assign n_use = (32'(floor_cnt_q) > MAX_FLOOR_COUNT) ? FLOOR_W'(MAX_FLOOR_COUNT) : floor_cnt_q;

	assign is_add  = (req_type_q == REQ_ADD_UP) || (req_type_q == REQ_ADD_DOWN);
	assign is_tick = (req_type_q == REQ_TICK);
	assign add_bad = (cf_q == '0) || (cf_q > n_q);
	assign do_rmw  = (is_add && !add_bad) || (is_tick && pend_cnt != '0);

	assign new_car = (target > car_q) ? car_q + 7'd1 :
		(target < car_q) ? car_q - 7'd1 : car_q;

	// A cleared floor only counts against pending when it lies within the floors in use
	assign clr_in_use = (mem_rd_data.up || mem_rd_data.dn) && (car_q <= n_q);
	assign pend_left  = pend_cnt - {{(FLOOR_W-1){1'b0}}, clr_in_use};

	assign beat.vld   = scan_vld_s1;
	assign beat.floor = floor_s1;
	assign beat.flags = mem_rd_data;

	ers_flag_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_flag_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (AW'(wr_floor_q)),
		.wr_data (mem_wr_data)
	);

	ers_target_scan u_target_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.beat     (beat),
		.car      (car_q),
		.dir      (dir_q),
		.target   (target),
		.pend_cnt (pend_cnt)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_nxt = (n_use == '0) ? ST_DECIDE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_idx_q == n_q) begin
					state_nxt = ST_LAST;
				end
			end
			ST_LAST: begin
				state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_nxt = do_rmw ? ST_READ : ST_DONE;
			end
			ST_READ: begin
				state_nxt = ST_WRITE;
			end
			ST_WRITE: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		req.ready   = 1'b0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = AW'(scan_idx_q);
		mem_wr_en   = 1'b0;
		mem_wr_data = '0;
		load_rsp    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_SCAN: begin
				mem_rd_en = 1'b1;
			end
			ST_READ: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = AW'(wr_floor_q);
			end
			ST_WRITE: begin
				mem_wr_en = 1'b1;
				if (is_add) begin
					mem_wr_data = mem_rd_data;
					if (req_type_q == REQ_ADD_UP) begin
						mem_wr_data.up = 1'b1;
					end else begin
						mem_wr_data.dn = 1'b1;
					end
				end
			end
			ST_DONE: begin
				load_rsp = !rsp_valid_q || rsp.ready;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			floor_cnt_q <= FLOOR_CNT_RESET;
			car_q       <= CAR_RESET;
			dir_q       <= DIR_IDLE;
			scan_vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			scan_vld_s1 <= mem_rd_en && (state_q == ST_SCAN);
			if (cfg_we) begin
				floor_cnt_q <= cfg_wdata;
			end
			// Step the car one floor toward the target
			if (state_q == ST_DECIDE && is_tick && pend_cnt != '0) begin
				car_q <= new_car;
				if (target > car_q) begin
					dir_q <= DIR_UP;
				end else if (target < car_q) begin
					dir_q <= DIR_DOWN;
				end
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		floor_s1 <= scan_idx_q;
		if (accept) begin
			req_type_q <= req.req_type;
			cf_q       <= req.call_floor;
			n_q        <= n_use;
			scan_idx_q <= 7'd1;
			moved_q    <= 1'b0;
			srv_up_q   <= 1'b0;
			srv_dn_q   <= 1'b0;
			rejected_q <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			scan_idx_q <= scan_idx_q + 7'd1;
		end
		if (state_q == ST_DECIDE) begin
			pending_q <= pend_cnt != '0;
			if (is_add) begin
				rejected_q <= add_bad;
				wr_floor_q <= cf_q;
			end else begin
				moved_q    <= new_car != car_q;
				wr_floor_q <= new_car;
			end
		end
		if (state_q == ST_WRITE) begin
			if (is_add) begin
				pending_q <= 1'b1;
			end else begin
				srv_up_q  <= mem_rd_data.up;
				srv_dn_q  <= mem_rd_data.dn;
				pending_q <= pend_left != '0;
			end
		end
		if (load_rsp) begin
			rsp_car_q   <= car_q;
			rsp_dir_q   <= dir_q;
			rsp_moved_q <= moved_q && is_tick;
			rsp_up_q    <= srv_up_q;
			rsp_dn_q    <= srv_dn_q;
			rsp_pend_q  <= pending_q;
			rsp_rej_q   <= rejected_q;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.car_floor        = rsp_car_q;
	assign rsp.travel_dir       = rsp_dir_q;
	assign rsp.car_moved        = rsp_moved_q;
	assign rsp.served_up_call   = rsp_up_q;
	assign rsp.served_down_call = rsp_dn_q;
	assign rsp.door_cycle       = rsp_up_q || rsp_dn_q;
	assign rsp.calls_pending    = rsp_pend_q;
	assign rsp.call_rejected    = rsp_rej_q;

	`ERS_ASSERT_NEXT(a_dir_sticky, clk, arst_n, dir_q != DIR_IDLE, dir_q != DIR_IDLE, "direction returned to idle")
	`ERS_ASSERT_NOW(a_car_range, clk, arst_n, 1'b1, car_q != '0 && 32'(car_q) <= MAX_FLOOR_COUNT, "car floor out of range")
	`ERS_ASSERT_NOW(a_beat_in_scan, clk, arst_n, scan_vld_s1, state_q == ST_SCAN || state_q == ST_LAST, "scan beat outside scan")
	`ERS_ASSERT_NEXT(a_accept_start, clk, arst_n, accept, state_q == ST_SCAN || state_q == ST_DECIDE, "accept did not start a scan")

endmodule

/* dv/tb_elevator_request_scheduler.sv */
// Self-checking testbench of the elevator request scheduler: directed and random traffic against a car model.
`timescale 1ns / 100ps

module tb_elevator_request_scheduler import ers_pkg::*; ();

	localparam int FLOOR_LIMIT = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 80;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [FLOOR_W-1:0] floor_no;
		ers_dir_t           dir;
		logic               moved;
		logic               served_up;
		logic               served_dn;
		logic               door;
		logic               pending;
		logic               rejected;
	} car_status_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [FLOOR_W-1:0] cfg_wdata;

	ers_req_if req_bus ();
	ers_rsp_if rsp_bus ();

	elevator_request_scheduler #(
		.MAX_FLOOR_COUNT(FLOOR_LIMIT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_bus),
		.rsp      (rsp_bus)
	);

	always #5 clk = ~clk;

	// Car model
	logic [FLOOR_W-1:0] floor_setting;
	logic [FLOOR_W-1:0] car_at;
	ers_dir_t           heading;
	bit                 up_calls [0:FLOOR_LIMIT];
	bit                 down_calls [0:FLOOR_LIMIT];

	car_status_t car_status_queue [$];
	int          mismatches = 0;
	int          cycle_count = 0;
	bit          steady_flow = 1'b0;
	bit          hold_results = 1'b0;

	function automatic int floors_live();
		return (int'(floor_setting) > FLOOR_LIMIT) ? FLOOR_LIMIT : int'(floor_setting);
	endfunction

	function automatic bit any_call(int n);
		int f;
		for (f = 1; f <= n; f++)
			if (up_calls[f] || down_calls[f])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic int choose_target(int n);
		int f, here, d, up_f, dn_f, up_d, dn_d;
		bit up_ok, dn_ok;
		here = int'(car_at);
		up_ok = 1'b0;
		dn_ok = 1'b0;
		up_f = 0;
		dn_f = 0;
		up_d = 0;
		dn_d = 0;
		if (heading == DIR_UP) begin
			for (f = here + 1; f <= n; f++)
				if (up_calls[f]) return f;
			for (f = n; f >= 1; f--)
				if (down_calls[f]) return f;
		end else if (heading == DIR_DOWN) begin
			for (f = (here - 1 < n) ? here - 1 : n; f >= 1; f--)
				if (down_calls[f]) return f;
			for (f = 1; f <= n; f++)
				if (up_calls[f]) return f;
		end
		// nearest call of each kind; lower floor wins within a kind
		for (f = 1; f <= n; f++) begin
			d = (f > here) ? f - here : here - f;
			if (up_calls[f] && (!up_ok || d < up_d)) begin
				up_ok = 1'b1;
				up_d = d;
				up_f = f;
			end
			if (down_calls[f] && (!dn_ok || d < dn_d)) begin
				dn_ok = 1'b1;
				dn_d = d;
				dn_f = f;
			end
		end
		if (up_ok && dn_ok)
			return (up_d <= dn_d) ? up_f : dn_f;
		if (up_ok)
			return up_f;
		return (dn_f != 0) ? dn_f : here;
	endfunction

	function automatic car_status_t predict_car_status(logic [1:0] kind,
			logic [FLOOR_W-1:0] floor_no);
		car_status_t s;
		int n, goal;
		s = '0;
		n = floors_live();
		if (kind == REQ_ADD_UP || kind == REQ_ADD_DOWN) begin
			if (floor_no == 0 || int'(floor_no) > n)
				s.rejected = 1'b1;
			else if (kind == REQ_ADD_UP)
				up_calls[floor_no] = 1'b1;
			else
				down_calls[floor_no] = 1'b1;
		end else if (kind == REQ_TICK && any_call(n)) begin
			goal = choose_target(n);
			if (goal > int'(car_at)) begin
				heading = DIR_UP;
				car_at = car_at + 1'b1;
				s.moved = 1'b1;
			end else if (goal < int'(car_at)) begin
				heading = DIR_DOWN;
				car_at = car_at - 1'b1;
				s.moved = 1'b1;
			end
			// clear calls at the new floor, even above the floors in use
			if (up_calls[car_at]) begin
				up_calls[car_at] = 1'b0;
				s.served_up = 1'b1;
			end
			if (down_calls[car_at]) begin
				down_calls[car_at] = 1'b0;
				s.served_dn = 1'b1;
			end
		end
		s.floor_no = car_at;
		s.dir = heading;
		s.door = s.served_up | s.served_dn;
		s.pending = any_call(n);
		return s;
	endfunction

	function automatic int idle_gap();
		int r;
		if (steady_flow)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(string what, logic [FLOOR_W-1:0] got,
			logic [FLOOR_W-1:0] want);
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want,
			cycle_count);
		mismatches++;
	endtask

	task automatic check_field(string what, logic [FLOOR_W-1:0] got,
			logic [FLOOR_W-1:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	task automatic send_request(logic [1:0] kind, logic [FLOOR_W-1:0] floor_no);
		int gap;
		req_bus.valid <= 1'b1;
		req_bus.req_type <= kind;
		req_bus.call_floor <= floor_no;
		do @(posedge clk); while (req_bus.ready !== 1'b1);
		car_status_queue.push_back(predict_car_status(kind, floor_no));
		gap = idle_gap();
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			req_bus.req_type <= 2'($urandom);
			req_bus.call_floor <= 7'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_request();
		int r, n;
		r = $urandom_range(0, 99);
		n = floors_live();
		if (r < 45)
			send_request(REQ_TICK, 7'($urandom));
		else if (r < 90)
			send_request($urandom_range(0, 1) ? REQ_ADD_DOWN : REQ_ADD_UP,
				(n == 0) ? 7'($urandom) : 7'($urandom_range(1, n)));
		else if (r < 96)
			send_request($urandom_range(0, 1) ? REQ_ADD_DOWN : REQ_ADD_UP, 7'($urandom));
		else
			send_request(REQ_UNUSED, 7'($urandom));
	endtask

	task automatic drain();
		req_bus.valid <= 1'b0;
		while (car_status_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_floor_count(logic [FLOOR_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		floor_setting = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_ticks(int count);
		repeat (count) send_request(REQ_TICK, 7'($urandom));
	endtask

	task automatic test_directed();
		send_ticks(1);
		send_request(REQ_ADD_UP, 7'd0);
		send_request(REQ_ADD_DOWN, 7'd11);
		send_request(REQ_ADD_UP, 7'd127);
		send_request(REQ_ADD_DOWN, 7'd64);
		send_request(REQ_UNUSED, 7'd127);
		// call at the car floor: served without a move
		send_request(REQ_ADD_UP, 7'd1);
		send_ticks(1);
		// up and down call on one floor while idle
		send_request(REQ_ADD_UP, 7'd4);
		send_request(REQ_ADD_DOWN, 7'd4);
		send_request(REQ_ADD_DOWN, 7'd2);
		send_ticks(4);
		send_request(REQ_ADD_DOWN, 7'd10);
		send_request(REQ_ADD_UP, 7'd7);
		send_request(REQ_ADD_DOWN, 7'd3);
		send_request(REQ_ADD_UP, 7'd10);
		send_ticks(6);
	endtask

	task automatic test_floor_count_changes();
		logic [FLOOR_W-1:0] sweep [5];
		sweep = '{7'd0, 7'd127, 7'd65, 7'd1, 7'd2};
		set_floor_count(7'd64);
		send_request(REQ_ADD_UP, 7'd40);
		send_request(REQ_ADD_DOWN, 7'd64);
		send_request(REQ_ADD_UP, 7'd63);
		send_ticks(30);
		// car stays above the new count and is drawn down
		set_floor_count(7'd5);
		send_request(REQ_ADD_DOWN, 7'd2);
		send_request(REQ_ADD_UP, 7'd6);
		send_ticks(32);
		// flags above the old count reappear
		set_floor_count(7'd64);
		send_ticks(12);
		foreach (sweep[i]) begin
			set_floor_count(sweep[i]);
			repeat (40) send_random_request();
		end
	endtask

	task automatic test_result_backpressure();
		set_floor_count(7'd8);
		steady_flow = 1'b1;
		hold_results = 1'b1;
		repeat (12) send_random_request();
		steady_flow = 1'b0;
	endtask

	task automatic test_steady_stream();
		set_floor_count(7'd12);
		steady_flow = 1'b1;
		repeat (100) send_random_request();
		steady_flow = 1'b0;
	endtask

	task automatic test_random_mix();
		int r;
		repeat (12) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				set_floor_count(7'($urandom_range(1, 16)));
			else if (r < 85)
				set_floor_count(7'($urandom_range(17, 64)));
			else if (r < 90)
				set_floor_count(7'd0);
			else
				set_floor_count(7'($urandom_range(64, 127)));
			repeat (75) send_random_request();
		end
	endtask

	// Result side: random stalls, one long hold on request
	initial begin : result_sink
		int gap;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_results) begin
				hold_results = 1'b0;
				rsp_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = idle_gap();
				if (gap > 0) begin
					rsp_bus.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				rsp_bus.ready <= 1'b1;
				repeat (steady_flow ? 0 : $urandom_range(0, 6)) @(posedge clk);
			end
		end
	end

	initial begin : result_check
		car_status_t want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
				if (car_status_queue.size() == 0) begin
					report_mismatch("unexpected beat", rsp_bus.car_floor, '0);
				end else begin
					want = car_status_queue.pop_front();
					check_field("car_floor", rsp_bus.car_floor, want.floor_no);
					check_field("travel_dir", 7'(rsp_bus.travel_dir), 7'(want.dir));
					check_field("car_moved", 7'(rsp_bus.car_moved), 7'(want.moved));
					check_field("served_up_call", 7'(rsp_bus.served_up_call),
						7'(want.served_up));
					check_field("served_down_call", 7'(rsp_bus.served_down_call),
						7'(want.served_dn));
					check_field("door_cycle", 7'(rsp_bus.door_cycle), 7'(want.door));
					check_field("calls_pending", 7'(rsp_bus.calls_pending),
						7'(want.pending));
					check_field("call_rejected", 7'(rsp_bus.call_rejected),
						7'(want.rejected));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : run
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_bus.valid <= 1'b0;
		req_bus.req_type <= REQ_TICK;
		req_bus.call_floor <= '0;
		floor_setting = FLOOR_CNT_RESET;
		car_at = CAR_RESET;
		heading = DIR_IDLE;
		foreach (up_calls[f]) begin
			up_calls[f] = 1'b0;
			down_calls[f] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_floor_count_changes();
		test_result_backpressure();
		test_steady_stream();
		test_random_mix();

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
